// File: sv/attribute_tlv_selector_core_defines.svh
// Assertion macros used by the RTL (ats_dp).
`ifndef ATTRIBUTE_TLV_SELECTOR_CORE_DEFINES_SVH
`define ATTRIBUTE_TLV_SELECTOR_CORE_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define ATS_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds in the cycle after trig.
`define ATS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: sv/ats_pkg.sv
package ats_pkg;
	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_VAL  = 2'd2;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_AH   = 2'd1;
	localparam logic [1:0] MODE_ESP  = 2'd2;

	localparam logic [1:0] REG_AUTH_EN = 2'd0;
	localparam logic [1:0] REG_ENC_EN  = 2'd1;
	localparam logic [1:0] REG_AH_MARK = 2'd2;
	localparam logic [1:0] REG_ESP_MARK = 2'd3;

	localparam int MAX_RES = 4;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_summary;
		logic [10:0] byte_count;
		logic        too_long;
	} res_t;

	typedef struct packed {
		logic store;
		logic clr_walk;
		logic rd_type;
		logic rd_len;
		logic set_found;
		logic adv_pos;
		logic commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_wanted;
		logic need_lookup;
		logic pos_end;
		logic type_hit;
		logic rem_lt2;
		logic step_over;
		logic no_result;
		logic out_free;
		logic emit_last;
	} sts_t;
endpackage

// File: sv/ats_ram.sv
module ats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: sv/ats_ctrl.sv
module ats_ctrl import ats_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_WALK   = 3'd2;
	localparam logic [2:0] ST_CMP_T  = 3'd3;
	localparam logic [2:0] ST_CMP_L  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0] state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.clr_walk = 1'b1;
				if (!sts.is_wanted) begin
					cmd.store = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.need_lookup) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_WALK: begin
				if (sts.pos_end) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_type = 1'b1;
					state_d = ST_CMP_T;
				end
			end
			ST_CMP_T: begin
				if (sts.type_hit) begin
					cmd.set_found = 1'b1;
					state_d = ST_FINISH;
				end else if (sts.rem_lt2) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_len = 1'b1;
					state_d = ST_CMP_L;
				end
			end
			ST_CMP_L: begin
				if (sts.step_over) begin
					state_d = ST_FINISH;
				end else begin
					cmd.adv_pos = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_FINISH: begin
				cmd.commit = 1'b1;
				state_d = sts.no_result ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: sv/ats_dp.sv
`include "attribute_tlv_selector_core_defines.svh"
module ats_dp import ats_pkg::*; #(
	parameter int OFFERED_MAX = 256,
	parameter int OUT_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        in_op,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_data,
	output logic [31:0] cfg_rdata,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output res_t        m_res,
	output logic        m_last
);
	localparam int AW  = $clog2(OFFERED_MAX);
	localparam int LW  = $clog2(OFFERED_MAX + 1);
	localparam int SW  = (LW > 8 ? LW : 9) + 1;
	localparam int WLW = $clog2(OUT_MAX + 2);

	logic auth_q, enc_q;
	logic [7:0] ah_q, esp_q;

	logic in_op_q, in_last_q;
	logic [7:0] in_byte_q;

	logic [LW-1:0] len_q, pos_q;
	logic closed_q, found_q;

	logic [1:0] phase_q, mode_q;
	logic [7:0] rem_q;
	logic taking_q, first_q;
	logic [10:0] sel_q;
	logic [WLW-1:0] wlen_q;

	res_t res_q [MAX_RES];
	logic [2:0] n_q, idx_q;
	logic out_v_q;

	logic [7:0] rd_data;
	logic [AW-1:0] raddr, waddr;
	logic ram_we;
	logic [LW-1:0] rem_w, pos_inc;
	logic [SW-1:0] step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auth_q <= 1'b0;
			enc_q  <= 1'b0;
			ah_q   <= '0;
			esp_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_AUTH_EN:  auth_q <= cfg_data[0];
				REG_ENC_EN:   enc_q  <= cfg_data[0];
				REG_AH_MARK:  ah_q   <= cfg_data;
				REG_ESP_MARK: esp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_AUTH_EN:  cfg_rdata = {31'd0, auth_q};
			REG_ENC_EN:   cfg_rdata = {31'd0, enc_q};
			REG_AH_MARK:  cfg_rdata = {24'd0, ah_q};
			REG_ESP_MARK: cfg_rdata = {24'd0, esp_q};
			default:      cfg_rdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_op_q   <= in_op;
			in_byte_q <= in_byte;
			in_last_q <= in_last;
		end
	end

	assign ram_we = cmd.store && (closed_q || len_q < LW'(OFFERED_MAX));
	assign waddr  = closed_q ? '0 : len_q[AW-1:0];
	assign pos_inc = pos_q + LW'(1);
	assign raddr  = cmd.rd_len ? pos_inc[AW-1:0] : pos_q[AW-1:0];

	ats_ram #(.WIDTH(8), .DEPTH(OFFERED_MAX)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (in_byte_q),
		.re    (cmd.rd_type || cmd.rd_len),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign rem_w = len_q - pos_q;
	assign step  = SW'(rd_data) + SW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			closed_q <= 1'b0;
			pos_q    <= '0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (closed_q) begin
					len_q <= LW'(1);
				end else if (len_q < LW'(OFFERED_MAX)) begin
					len_q <= len_q + LW'(1);
				end
				closed_q <= in_last_q;
			end
			if (cmd.clr_walk) begin
				pos_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.adv_pos) begin
				pos_q <= pos_q + step[LW-1:0];
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
		end
	end

	logic [WLW-1:0] wlen_d;
	logic ok_emit, ah_hit, esp_hit, first_t, hit_pre, sel_hit, tl;
	logic [1:0] mode_t, phase_d, mode_d;
	logic [7:0] rem_d;
	logic taking_d, first_d;
	logic [10:0] sel_d;
	res_t res_d [MAX_RES];
	logic [2:0] n_d;

	assign wlen_d  = (wlen_q <= WLW'(OUT_MAX)) ? wlen_q + WLW'(1) : wlen_q;
	assign ok_emit = wlen_d <= WLW'(OUT_MAX);
	assign ah_hit  = (in_byte_q == ah_q) && auth_q;
	assign esp_hit = (in_byte_q == esp_q) && enc_q;
	assign mode_t  = ah_hit ? MODE_AH : (esp_hit ? MODE_ESP : mode_q);
	assign first_t = ah_hit || esp_hit || first_q;
	assign hit_pre = (phase_q == PH_TYPE) && ok_emit && (mode_t != MODE_NONE) && first_t
		&& (in_byte_q != ah_q) && (in_byte_q != esp_q);
	assign sel_hit = hit_pre && found_q;
	assign tl = wlen_d > WLW'(OUT_MAX);

	always_comb begin
		phase_d  = phase_q;
		mode_d   = mode_q;
		rem_d    = rem_q;
		taking_d = taking_q;
		first_d  = first_q;
		sel_d    = sel_q;
		n_d      = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i] = '0;
		end
		case (phase_q)
			PH_TYPE: begin
				mode_d   = mode_t;
				first_d  = first_t;
				taking_d = 1'b0;
				if (sel_hit) begin
					res_d[0].out_byte = (mode_t == MODE_AH) ? ah_q : esp_q;
					res_d[2].out_byte = in_byte_q;
					n_d      = 3'd3;
					sel_d    = sel_q + 11'd3;
					first_d  = 1'b0;
					taking_d = 1'b1;
				end
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				rem_d = in_byte_q;
				if (taking_q && ok_emit) begin
					res_d[0].out_byte = in_byte_q;
					n_d   = 3'd1;
					sel_d = sel_q + 11'd1;
				end
				phase_d = (in_byte_q != 8'd0) ? PH_VAL : PH_TYPE;
			end
			default: begin
				if (taking_q && ok_emit) begin
					res_d[0].out_byte = in_byte_q;
					n_d   = 3'd1;
					sel_d = sel_q + 11'd1;
				end
				if (rem_q > 8'd1) begin
					rem_d = rem_q - 8'd1;
				end else begin
					rem_d   = 8'd0;
					phase_d = PH_TYPE;
				end
			end
		endcase
		if (in_last_q) begin
			res_d[n_d[1:0]].is_summary = 1'b1;
			res_d[n_d[1:0]].byte_count = tl ? 11'd0 : sel_d;
			res_d[n_d[1:0]].too_long   = tl;
			n_d = n_d + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			mode_q   <= MODE_NONE;
			rem_q    <= '0;
			taking_q <= 1'b0;
			first_q  <= 1'b0;
			sel_q    <= '0;
			wlen_q   <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				n_q   <= n_d;
				idx_q <= '0;
				if (in_last_q) begin
					phase_q  <= PH_TYPE;
					mode_q   <= MODE_NONE;
					rem_q    <= '0;
					taking_q <= 1'b0;
					first_q  <= 1'b0;
					sel_q    <= '0;
					wlen_q   <= '0;
				end else begin
					phase_q  <= phase_d;
					mode_q   <= mode_d;
					rem_q    <= rem_d;
					taking_q <= taking_d;
					first_q  <= first_d;
					sel_q    <= sel_d;
					wlen_q   <= wlen_d;
				end
			end
			if (cmd.load_out) begin
				out_v_q <= 1'b1;
				idx_q   <= idx_q + 3'd1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			m_res  <= res_q[idx_q[1:0]];
			m_last <= (idx_q + 3'd1 == n_q);
		end
	end

	assign m_tvalid = out_v_q;

	assign sts.is_wanted   = in_op_q;
	assign sts.need_lookup = hit_pre;
	assign sts.pos_end     = pos_q >= len_q;
	assign sts.type_hit    = rd_data == in_byte_q;
	assign sts.rem_lt2     = rem_w < LW'(2);
	assign sts.step_over   = step > SW'(rem_w);
	assign sts.no_result   = n_d == 3'd0;
	assign sts.out_free    = !out_v_q || m_tready;
	assign sts.emit_last   = (idx_q + 3'd1 == n_q);

	`ATS_ASSERT_SAME(a_load_free, cmd.load_out, !out_v_q || m_tready, "output overwritten")
	`ATS_ASSERT_SAME(a_idx_range, cmd.load_out, idx_q < n_q, "emit past result count")
	`ATS_ASSERT_SAME(a_len_max, 1'b1, len_q <= LW'(OFFERED_MAX), "offered length overflow")
	`ATS_ASSERT_NEXT(a_found_fin, cmd.set_found, found_q, "lookup hit lost")
endmodule

// File: sv/attribute_tlv_selector_core.sv
// Sequence: an offered beat is stored in EVAL; a wanted beat passes EVAL, the walk
// if needed, FINISH and, with results, EMIT: one output beat per cycle unless m_tready
// stalls (up to 4 beats per input beat). One input beat at a time; the walk uses
// WALK, CMP_T, CMP_L per element passed over, on the single offered-store read port.
// Reset: arst_n clears control, walk, wanted-side state and config registers to zero;
// input capture and result registers and the offered store are undefined until written.
module attribute_tlv_selector_core import ats_pkg::*; #(
	parameter int OFFERED_MAX = 256,
	parameter int OUT_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] operation
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] out_byte, [18:8] byte_count, [19] too_long
	output logic        m_tuser,  // [0] is_summary
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cmd_t cmd;
	sts_t sts;
	res_t res;

	assign pready = 1'b1;

	ats_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ats_dp #(.OFFERED_MAX(OFFERED_MAX), .OUT_MAX(OUT_MAX)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_tvalid && s_tready),
		.in_op     (s_tuser),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cfg_we    (psel && penable && pwrite),
		.cfg_idx   (paddr[3:2]),
		.cfg_data  (pwdata[7:0]),
		.cfg_rdata (prdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (res),
		.m_last    (m_tlast)
	);

	assign m_tdata = {4'd0, res.too_long, res.byte_count, res.out_byte};
	assign m_tuser = res.is_summary;
endmodule
